FILE: src/csp_pkg.sv
package csp_pkg;

    localparam int COORD_W    = 32;
    localparam int RADIUS_W   = 31;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int U_ONE_BITS = 30;
    // Scaled component: signed, magnitude in [2^29, 2^30) for the largest one.
    localparam int SC_W       = 31;
    // Width of a vector component that goes into block scaling.
    localparam int SC_IN_W    = 36;

    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_Y    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TOP_Z    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 3'd6;

    localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TOP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BOTTOM = 2'd2;

    typedef logic [2:0][COORD_W-1:0] coord3_t;
    typedef logic [2:0][SC_W-1:0]    sc3_t;
    typedef logic [2:0][SC_IN_W-1:0] wide3_t;

    // Shifts a signed vector so that its largest magnitude lies in [2^29, 2^30).
    // Right shifts truncate the magnitude. A zero vector stays zero.
    function automatic sc3_t block_scale(input wide3_t v);
        logic [2:0][SC_IN_W-1:0] m;
        logic [SC_IN_W-1:0]      mx;
        logic [SC_IN_W-1:0]      s;
        int                      p;
        sc3_t                    w;
        mx = '0;
        p  = 0;
        for (int i = 0; i < 3; i++)
        begin
            m[i] = v[i][SC_IN_W-1] ? (~v[i] + 1'b1) : v[i];
            if (m[i] > mx)
            begin
                mx = m[i];
            end
        end
        for (int i = 0; i < SC_IN_W; i++)
        begin
            if (mx[i])
            begin
                p = i;
            end
        end
        for (int i = 0; i < 3; i++)
        begin
            if (p >= 29)
            begin
                s = m[i] >> (p - 29);
            end
            else
            begin
                s = m[i] << (29 - p);
            end
            w[i] = v[i][SC_IN_W-1] ? SC_W'(~s + 1'b1) : SC_W'(s);
        end
        return w;
    endfunction

endpackage

FILE: src/csp_if.sv
interface csp_query_if;
    logic                              valid;
    logic                              ready;
    logic [csp_pkg::MODE_W-1:0]        mode;
    logic signed [csp_pkg::COORD_W-1:0] dir_x;
    logic signed [csp_pkg::COORD_W-1:0] dir_y;
    logic signed [csp_pkg::COORD_W-1:0] dir_z;
    modport source (output valid, mode, dir_x, dir_y, dir_z, input ready);
    modport sink (input valid, mode, dir_x, dir_y, dir_z, output ready);
endinterface

interface csp_result_if;
    logic                              valid;
    logic                              ready;
    logic signed [csp_pkg::COORD_W-1:0] point_x;
    logic signed [csp_pkg::COORD_W-1:0] point_y;
    logic signed [csp_pkg::COORD_W-1:0] point_z;
    logic                              used_top;
    modport source (output valid, point_x, point_y, point_z, used_top, input ready);
    modport sink (input valid, point_x, point_y, point_z, used_top, output ready);
endinterface

interface csp_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [csp_pkg::CFG_IDX_W-1:0]   index;
    logic [csp_pkg::COORD_W-1:0]     data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: src/csp_spine.sv
module csp_spine (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  csp_pkg::coord3_t bot,
    input  csp_pkg::coord3_t top,
    output logic             busy,
    output csp_pkg::sc3_t    u
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]    state_reg, state_next;
    logic          pend_reg, pend_next;
    logic [5:0]    cnt_reg, cnt_next;
    logic [1:0]    comp_reg, comp_next;
    csp_pkg::sc3_t ws_reg, ws_next;
    csp_pkg::sc3_t u_reg, u_next;
    logic [61:0]   acc_reg, acc_next;
    logic [30:0]   root_reg, root_next;
    logic [33:0]   rem_reg, rem_next;
    logic [31:0]   dnum_reg, dnum_next;
    logic [30:0]   drem_reg, drem_next;
    logic [31:0]   q_reg, q_next;

    csp_pkg::wide3_t    sp;
    logic signed [30:0] wsel;
    logic [29:0]        wmag;
    logic [61:0]        sqv;
    logic [61:0]        dn0;
    logic [33:0]        rem2;
    logic [33:0]        trial;
    logic [31:0]        drem2;
    logic [31:0]        qf;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            sp[i] = 36'($signed(top[i])) - 36'($signed(bot[i]));
        end
        wsel  = $signed(ws_reg[comp_reg]);
        wmag  = wsel[30] ? 30'(-wsel) : wsel[29:0];
        sqv   = 62'(62'(wsel) * 62'(wsel));
        dn0   = {2'b00, wmag, 30'd0} + 62'(root_reg >> 1);
        rem2  = {rem_reg[31:0], acc_reg[61:60]};
        trial = {1'b0, root_reg, 2'b01};
        drem2 = {drem_reg, dnum_reg[31]};
        qf    = {q_reg[30:0], (drem2 >= {1'b0, root_reg})};

        state_next = state_reg;
        cnt_next   = cnt_reg;
        comp_next  = comp_reg;
        ws_next    = ws_reg;
        u_next     = u_reg;
        acc_next   = acc_reg;
        root_next  = root_reg;
        rem_next   = rem_reg;
        dnum_next  = dnum_reg;
        drem_next  = drem_reg;
        q_next     = q_reg;
        pend_next  = pend_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next  = 1'b0;
                    ws_next    = csp_pkg::block_scale(sp);
                    acc_next   = '0;
                    comp_next  = '0;
                    state_next = ST_SQ;
                end
            end
            ST_SQ:
            begin
                acc_next = acc_reg + sqv;
                if (comp_reg == 2'd2)
                begin
                    state_next = ST_ROOT;
                    cnt_next   = '0;
                    root_next  = '0;
                    rem_next   = '0;
                end
                else
                begin
                    comp_next = comp_reg + 2'd1;
                end
            end
            ST_ROOT:
            begin
                if (rem2 >= trial)
                begin
                    rem_next  = rem2 - trial;
                    root_next = {root_reg[29:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem2;
                    root_next = {root_reg[29:0], 1'b0};
                end
                acc_next = {acc_reg[59:0], 2'b00};
                if (cnt_reg == 6'd30)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                    comp_next  = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 6'd1;
                end
            end
            ST_DIV:
            begin
                if (cnt_reg == 6'd0)
                begin
                    // A zero spine has a zero length and gives a zero unit vector.
                    if (root_reg == '0)
                    begin
                        u_next     = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        drem_next = {1'b0, dn0[61:32]};
                        dnum_next = dn0[31:0];
                        q_next    = '0;
                        cnt_next  = 6'd1;
                    end
                end
                else
                begin
                    if (drem2 >= {1'b0, root_reg})
                    begin
                        drem_next = 31'(drem2 - {1'b0, root_reg});
                    end
                    else
                    begin
                        drem_next = drem2[30:0];
                    end
                    dnum_next = {dnum_reg[30:0], 1'b0};
                    q_next    = qf;
                    if (cnt_reg == 6'd32)
                    begin
                        u_next[comp_reg] = wsel[30] ? 31'(-qf[30:0]) : qf[30:0];
                        cnt_next = '0;
                        if (comp_reg == 2'd2)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            comp_next = comp_reg + 2'd1;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (start)
        begin
            pend_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= 1'b1;
            cnt_reg   <= '0;
            comp_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            cnt_reg   <= cnt_next;
            comp_reg  <= comp_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ws_reg   <= ws_next;
        u_reg    <= u_next;
        acc_reg  <= acc_next;
        root_reg <= root_next;
        rem_reg  <= rem_next;
        dnum_reg <= dnum_next;
        drem_reg <= drem_next;
        q_reg    <= q_next;
    end

    assign busy = pend_reg || (state_reg != ST_IDLE);
    assign u    = u_reg;

endmodule

FILE: src/cylinder_support_point.sv
// Cylinder support point: for each query word (mode, direction) it returns the
// point of the configured cylinder furthest along the direction, and which end
// was used. Coordinates are signed Q16.16; results saturate to 32 bits.
// Channels: query (sink), result (source), cfg (sink, always ready). A cfg word
// writes one register by index; the user must let writes go in only while no
// query is in flight, as the block does not enforce it. The pipeline takes one
// query word per cycle while not held: products, dot, disc vector, scaling,
// a 31-stage square root and a 33-stage divider per component.
// After reset, and after any write of an end point, a sequential unit derives
// the unit spine vector; query.ready stays low meanwhile.
// Radius writes take effect at once. When result.ready is low with a result
// waiting, the whole pipeline holds and query.ready drops; nothing is lost.
module cylinder_support_point #(
    parameter int FRAC_BITS = 16
) (
    input logic               clk,
    input logic               rst_n,
    csp_query_if.sink         query,
    csp_result_if.source      result,
    csp_cfg_if.sink           cfg
);

    localparam int SIW        = csp_pkg::SC_IN_W;
    localparam int TOL_INT    = ((1 << FRAC_BITS) + 500) / 1000;
    localparam logic [SIW-1:0] DISC_TOL = SIW'(TOL_INT);
    localparam int ROOT_STEPS = 31;
    localparam int DIV_STEPS  = 33;

    typedef struct packed {
        logic             top;
        logic             tiny;
        logic [2:0]       neg;
        logic [2:0][60:0] num;
        logic [61:0]      v;
        logic [30:0]      root;
        logic [33:0]      rem;
    } root_st_t;

    typedef struct packed {
        logic             top;
        logic             tiny;
        logic [2:0]       neg;
        logic [30:0]      len;
        logic [2:0][61:0] n;
        logic [2:0][31:0] rem;
        logic [2:0][32:0] q;
    } div_st_t;

    function automatic logic signed [35:0] rnd30(input logic signed [64:0] x);
        logic [64:0] m;
        logic [64:0] r;
        m = x[64] ? 65'(-x) : 65'(x);
        r = (m + (65'd1 << 29)) >> 30;
        return x[64] ? -$signed(36'(r)) : $signed(36'(r));
    endfunction

    // Configuration registers.
    csp_pkg::coord3_t bot_reg, top_reg;
    logic [csp_pkg::RADIUS_W-1:0] radius_reg;
    logic cfg_we;
    logic spine_busy;
    csp_pkg::sc3_t u;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bot_reg    <= '0;
            top_reg    <= {32'd0, 32'(1 << FRAC_BITS), 32'd0};
            radius_reg <= csp_pkg::RADIUS_W'(1 << FRAC_BITS);
        end
        else if (cfg_we)
        begin
            case (cfg.index)
                csp_pkg::REG_BOTTOM_X: bot_reg[0] <= cfg.data;
                csp_pkg::REG_BOTTOM_Y: bot_reg[1] <= cfg.data;
                csp_pkg::REG_BOTTOM_Z: bot_reg[2] <= cfg.data;
                csp_pkg::REG_TOP_X:    top_reg[0] <= cfg.data;
                csp_pkg::REG_TOP_Y:    top_reg[1] <= cfg.data;
                csp_pkg::REG_TOP_Z:    top_reg[2] <= cfg.data;
                csp_pkg::REG_RADIUS:   radius_reg <= cfg.data[csp_pkg::RADIUS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    csp_spine u_spine (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cfg_we && (cfg.index <= csp_pkg::REG_TOP_Z)),
        .bot   (bot_reg),
        .top   (top_reg),
        .busy  (spine_busy),
        .u     (u)
    );

    // Pipeline control: every stage advances when the output register can move.
    logic res_vld_reg;
    logic en;
    logic in_take;

    assign en          = !res_vld_reg || result.ready;
    assign query.ready = en && !spine_busy;
    assign in_take     = query.valid && query.ready;

    // Stage A: accepted word.
    logic                     a_vld_reg;
    logic [csp_pkg::MODE_W-1:0] a_mode_reg;
    csp_pkg::coord3_t         a_d_reg;

    // Stage B: products.
    logic                     b_vld_reg;
    logic [csp_pkg::MODE_W-1:0] b_mode_reg;
    csp_pkg::coord3_t         b_d_reg;
    logic signed [64:0]       b_p_reg [3];
    logic signed [62:0]       b_q_reg [3];
    logic signed [32:0]       bmt [3];
    logic signed [64:0]       pb [3];
    logic signed [62:0]       qb [3];

    // Stage C: end choice and dot product along the spine.
    logic                     c_vld_reg, c_top_reg;
    csp_pkg::coord3_t         c_d_reg;
    logic signed [33:0]       c_dot_reg;
    logic signed [66:0]       psum;
    logic signed [64:0]       qsum;
    logic                     c_top;

    // Stage D: spine projection.
    logic                     d_vld_reg, d_top_reg;
    csp_pkg::coord3_t         d_d_reg;
    logic signed [64:0]       d_m_reg [3];

    // Stage E: disc vector.
    logic                     e_vld_reg, e_top_reg, e_tiny_reg;
    csp_pkg::wide3_t          e_disc_reg;
    csp_pkg::wide3_t          disc;
    logic                     tiny;

    // Stage F: block-scaled disc vector.
    logic                     f_vld_reg, f_top_reg, f_tiny_reg;
    csp_pkg::sc3_t            f_w_reg;

    // Stage G: squares and radius products.
    logic                     g_vld_reg, g_top_reg, g_tiny_reg;
    logic [2:0]               g_neg_reg;
    logic [61:0]              g_sq_reg [3];
    logic [2:0][60:0]         g_num_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            bmt[i] = 33'($signed(bot_reg[i])) - 33'($signed(top_reg[i]));
            pb[i]  = 65'($signed(a_d_reg[i])) * 65'(bmt[i]);
            qb[i]  = 63'($signed(u[i])) * 63'($signed(a_d_reg[i]));
        end
        psum = 67'(b_p_reg[0]) + 67'(b_p_reg[1]) + 67'(b_p_reg[2]);
        qsum = 65'(b_q_reg[0]) + 65'(b_q_reg[1]) + 65'(b_q_reg[2]);
        case (b_mode_reg)
            csp_pkg::MODE_TOP:    c_top = 1'b1;
            csp_pkg::MODE_BOTTOM: c_top = 1'b0;
            default:              c_top = psum[66];
        endcase
        tiny = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            disc[i] = SIW'(36'($signed(d_d_reg[i])) - rnd30(d_m_reg[i]));
            if ((disc[i][SIW-1] ? (~disc[i] + 1'b1) : disc[i]) >= DISC_TOL)
            begin
                tiny = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            a_vld_reg <= in_take;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_mode_reg <= query.mode;
            a_d_reg    <= {query.dir_z, query.dir_y, query.dir_x};
            b_mode_reg <= a_mode_reg;
            b_d_reg    <= a_d_reg;
            for (int i = 0; i < 3; i++)
            begin
                b_p_reg[i] <= pb[i];
                b_q_reg[i] <= qb[i];
            end
            c_top_reg <= c_top;
            c_d_reg   <= b_d_reg;
            c_dot_reg <= 34'(rnd30(qsum));
            d_top_reg <= c_top_reg;
            d_d_reg   <= c_d_reg;
            for (int i = 0; i < 3; i++)
            begin
                d_m_reg[i] <= 65'($signed(u[i])) * 65'(c_dot_reg);
            end
            e_top_reg  <= d_top_reg;
            e_tiny_reg <= tiny;
            e_disc_reg <= disc;
            f_top_reg  <= e_top_reg;
            f_tiny_reg <= e_tiny_reg;
            f_w_reg    <= csp_pkg::block_scale(e_disc_reg);
            g_top_reg  <= f_top_reg;
            g_tiny_reg <= f_tiny_reg;
            for (int i = 0; i < 3; i++)
            begin
                g_neg_reg[i] <= f_w_reg[i][30];
                g_sq_reg[i]  <= 62'(62'($signed(f_w_reg[i])) * 62'($signed(f_w_reg[i])));
                g_num_reg[i] <= 61'(f_w_reg[i][30] ? 30'(-$signed(f_w_reg[i]))
                                                   : f_w_reg[i][29:0])
                                * 61'(radius_reg);
            end
        end
    end

    // Square root of the squared disc length, one root bit per stage.
    logic     sq_vld_reg [ROOT_STEPS+1];
    root_st_t sq_reg     [ROOT_STEPS+1];
    root_st_t sq_next    [ROOT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            sq_vld_reg[0] <= g_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg[0].top  <= g_top_reg;
            sq_reg[0].tiny <= g_tiny_reg;
            sq_reg[0].neg  <= g_neg_reg;
            sq_reg[0].num  <= g_num_reg;
            sq_reg[0].v    <= g_sq_reg[0] + g_sq_reg[1] + g_sq_reg[2];
            sq_reg[0].root <= '0;
            sq_reg[0].rem  <= '0;
        end
    end

    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_root
        localparam int K = ROOT_STEPS - 1 - j;
        logic [33:0] rem2;
        logic [33:0] trial;

        always_comb
        begin
            sq_next[j] = sq_reg[j];
            rem2  = {sq_reg[j].rem[31:0], sq_reg[j].v[2*K+1:2*K]};
            trial = {1'b0, sq_reg[j].root, 2'b01};
            if (rem2 >= trial)
            begin
                sq_next[j].rem  = rem2 - trial;
                sq_next[j].root = {sq_reg[j].root[29:0], 1'b1};
            end
            else
            begin
                sq_next[j].rem  = rem2;
                sq_next[j].root = {sq_reg[j].root[29:0], 1'b0};
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                sq_vld_reg[j+1] <= sq_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_reg[j+1] <= sq_next[j];
            end
        end
    end

    // Rounded division of |w| * radius by the length, one quotient bit per stage.
    logic    dv_vld_reg [DIV_STEPS+1];
    div_st_t dv_reg     [DIV_STEPS+1];
    div_st_t dv_next    [DIV_STEPS];
    logic [2:0][61:0] n0;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            n0[i] = {1'b0, sq_reg[ROOT_STEPS].num[i]} + 62'(sq_reg[ROOT_STEPS].root >> 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            dv_vld_reg[0] <= sq_vld_reg[ROOT_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_reg[0].top  <= sq_reg[ROOT_STEPS].top;
            dv_reg[0].tiny <= sq_reg[ROOT_STEPS].tiny;
            dv_reg[0].neg  <= sq_reg[ROOT_STEPS].neg;
            dv_reg[0].len  <= sq_reg[ROOT_STEPS].root;
            dv_reg[0].n    <= n0;
            for (int i = 0; i < 3; i++)
            begin
                dv_reg[0].rem[i] <= {3'b000, n0[i][61:33]};
            end
            dv_reg[0].q <= '0;
        end
    end

    for (genvar j = 0; j < DIV_STEPS; j++)
    begin : g_div
        localparam int K = DIV_STEPS - 1 - j;
        logic [2:0][31:0] rem2;

        always_comb
        begin
            dv_next[j] = dv_reg[j];
            for (int i = 0; i < 3; i++)
            begin
                rem2[i] = {dv_reg[j].rem[i][30:0], dv_reg[j].n[i][K]};
                if (rem2[i] >= {1'b0, dv_reg[j].len})
                begin
                    dv_next[j].rem[i] = rem2[i] - {1'b0, dv_reg[j].len};
                    dv_next[j].q[i]   = {dv_reg[j].q[i][31:0], 1'b1};
                end
                else
                begin
                    dv_next[j].rem[i] = rem2[i];
                    dv_next[j].q[i]   = {dv_reg[j].q[i][31:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_vld_reg[j+1] <= 1'b0;
            end
            else if (en)
            begin
                dv_vld_reg[j+1] <= dv_vld_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_reg[j+1] <= dv_next[j];
            end
        end
    end

    // Output stage: chosen end plus offset, saturated.
    csp_pkg::coord3_t   pt_reg, pt_next;
    logic               used_top_reg;
    logic signed [34:0] off [3];
    logic signed [34:0] sum [3];
    div_st_t            fin;

    always_comb
    begin
        fin = dv_reg[DIV_STEPS];
        for (int i = 0; i < 3; i++)
        begin
            off[i] = $signed({2'b00, fin.q[i]});
            if (fin.neg[i])
            begin
                off[i] = -off[i];
            end
            if (fin.tiny || (fin.len == '0))
            begin
                off[i] = '0;
            end
            sum[i] = 35'($signed(fin.top ? top_reg[i] : bot_reg[i])) + off[i];
            if (sum[i] > 35'sd2147483647)
            begin
                pt_next[i] = 32'h7FFF_FFFF;
            end
            else if (sum[i] < -35'sd2147483648)
            begin
                pt_next[i] = 32'h8000_0000;
            end
            else
            begin
                pt_next[i] = sum[i][31:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            res_vld_reg <= dv_vld_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pt_reg       <= pt_next;
            used_top_reg <= fin.top;
        end
    end

    assign result.valid    = res_vld_reg;
    assign result.point_x  = pt_reg[0];
    assign result.point_y  = pt_reg[1];
    assign result.point_z  = pt_reg[2];
    assign result.used_top = used_top_reg;

endmodule

FILE: test/tb_cylinder_support_point.sv
`timescale 1ns / 1ps

module tb_cylinder_support_point;

    typedef longint vec3_t[3];

    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [31:0] pz;
        logic        top;
    } support_t;

    typedef struct {
        logic [csp_pkg::MODE_W-1:0] mode;
        logic [31:0]       dx;
        logic [31:0]       dy;
        logic [31:0]       dz;
        bit                typed;
        support_t          want;
    } query_row_t;

    localparam longint DISC_TOL = ((longint'(1) << 16) + 500) / 1000;
    localparam longint COORD_MAX = (longint'(1) << 31) - 1;
    localparam longint COORD_MIN = -(longint'(1) << 31);
    localparam int CYCLE_LIMIT = 2000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    csp_query_if  query();
    csp_result_if result();
    csp_cfg_if    cfg();

    cylinder_support_point uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query),
        .result (result),
        .cfg    (cfg)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Shadow copy of the cylinder registers.
    longint bottom_pt[3];
    longint top_pt[3];
    longint radius_val;

    support_t points_due[$];
    support_t typed_due[$];
    bit       typed_flag[$];
    int       errors = 0;
    int       cycles = 0;
    int       idle_pct = 0;
    int       stall_pct = 0;
    int       hold_len = 0;

    function automatic longint unsigned magn(longint x);
        return x < 0 ? longint'(0) - x : x;
    endfunction

    function automatic longint signed_mag(bit neg, longint unsigned m);
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint round_shift(longint x, int k);
        longint unsigned m;
        m = (magn(x) + (longint'(1) << (k - 1))) >> k;
        return signed_mag(x < 0, m);
    endfunction

    function automatic longint round_div(longint x, longint unsigned den);
        longint unsigned m;
        m = (magn(x) + den / 2) / den;
        return signed_mag(x < 0, m);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic vec3_t normalize_range(vec3_t v);
        longint unsigned m;
        int dn;
        int up;
        vec3_t w;
        m = 0;
        dn = 0;
        up = 0;
        for (int i = 0; i < 3; i++)
            if (magn(v[i]) > m)
                m = magn(v[i]);
        for (int i = 0; i < 3; i++)
            w[i] = 0;
        if (m == 0)
            return w;
        while (m >= (longint'(1) << 30))
        begin
            m = m >> 1;
            dn++;
        end
        while (m < (longint'(1) << 29))
        begin
            m = m << 1;
            up++;
        end
        for (int i = 0; i < 3; i++)
            w[i] = signed_mag(v[i] < 0, (magn(v[i]) >> dn) << up);
        return w;
    endfunction

    function automatic longint unsigned length_of(vec3_t w);
        return floor_sqrt(longint'(w[0] * w[0] + w[1] * w[1] + w[2] * w[2]));
    endfunction

    function automatic logic [31:0] clamp32(longint x);
        if (x > COORD_MAX)
            x = COORD_MAX;
        if (x < COORD_MIN)
            x = COORD_MIN;
        return x[31:0];
    endfunction

    function automatic support_t support_of(logic [csp_pkg::MODE_W-1:0] mode,
                                            logic [31:0] dx, logic [31:0] dy,
                                            logic [31:0] dz);
        vec3_t d;
        vec3_t spine;
        vec3_t u;
        vec3_t disc;
        vec3_t w;
        vec3_t off;
        longint unsigned len;
        longint acc;
        longint dot;
        logic signed [127:0] cmp;
        logic signed [127:0] da;
        logic signed [127:0] db;
        bit pick_top;
        bit tiny;
        support_t r;
        d[0] = longint'($signed(dx));
        d[1] = longint'($signed(dy));
        d[2] = longint'($signed(dz));
        cmp = 0;
        for (int i = 0; i < 3; i++)
        begin
            spine[i] = top_pt[i] - bottom_pt[i];
            da = d[i];
            db = bottom_pt[i] - top_pt[i];
            cmp = cmp + da * db;
        end
        if (mode == csp_pkg::MODE_TOP)
            pick_top = 1'b1;
        else if (mode == csp_pkg::MODE_BOTTOM)
            pick_top = 1'b0;
        else
            pick_top = cmp < 0;

        w = normalize_range(spine);
        len = length_of(w);
        for (int i = 0; i < 3; i++)
            u[i] = (len != 0) ? round_div(w[i] * (longint'(1) << 30), len) : 0;
        acc = u[0] * d[0] + u[1] * d[1] + u[2] * d[2];
        dot = round_shift(acc, 30);
        tiny = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            disc[i] = d[i] - round_shift(u[i] * dot, 30);
            if (longint'(magn(disc[i])) >= DISC_TOL)
                tiny = 1'b0;
            off[i] = 0;
        end
        if (!tiny)
        begin
            w = normalize_range(disc);
            len = length_of(w);
            if (len != 0)
                for (int i = 0; i < 3; i++)
                    off[i] = round_div(w[i] * radius_val, len);
        end
        r.px = clamp32((pick_top ? top_pt[0] : bottom_pt[0]) + off[0]);
        r.py = clamp32((pick_top ? top_pt[1] : bottom_pt[1]) + off[1]);
        r.pz = clamp32((pick_top ? top_pt[2] : bottom_pt[2]) + off[2]);
        r.top = pick_top;
        return r;
    endfunction

    function automatic bit differs(support_t a);
        return result.point_x !== a.px || result.point_y !== a.py ||
               result.point_z !== a.pz || result.used_top !== a.top;
    endfunction

    always @(posedge clk)
    begin
        support_t e;
        support_t t;
        bit has_typed;
        if (rst_n && result.valid && result.ready)
        begin
            if (points_due.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word %h %h %h %b", result.point_x,
                             result.point_y, result.point_z, result.used_top);
            end
            else
            begin
                e = points_due.pop_front();
                t = typed_due.pop_front();
                has_typed = typed_flag.pop_front();
                if (differs(e) || (has_typed && differs(t)))
                begin
                    errors++;
                    if (errors <= 10)
                        $display("mismatch: expected %h %h %h %b (typed %h %h %h %b), %s",
                                 e.px, e.py, e.pz, e.top, t.px, t.py, t.pz, t.top,
                                 $sformatf("got %h %h %h %b", result.point_x,
                                           result.point_y, result.point_z,
                                           result.used_top));
                end
            end
        end
    end

    // Receiver: random stalls, plus an optional long hold-off counted here.
    always @(posedge clk)
    begin
        int hold_cnt;
        if (!rst_n)
        begin
            result.ready <= 1'b0;
            hold_cnt = 0;
        end
        else
        begin
            if (hold_len != 0)
            begin
                hold_cnt = hold_len;
                hold_len = 0;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result.ready <= 1'b0;
            end
            else
            begin
                result.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // The expected support point is queued at the edge where the word is accepted.
    task automatic send_query(logic [csp_pkg::MODE_W-1:0] mode, logic [31:0] dx,
                              logic [31:0] dy, logic [31:0] dz, bit typed,
                              support_t want);
        if ($urandom_range(99) < idle_pct)
        begin
            query.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        query.valid <= 1'b1;
        query.mode  <= mode;
        query.dir_x <= dx;
        query.dir_y <= dy;
        query.dir_z <= dz;
        do
            @(posedge clk);
        while (!query.ready);
        points_due.push_back(support_of(mode, dx, dy, dz));
        typed_flag.push_back(typed);
        typed_due.push_back(want);
    endtask

    task automatic write_reg(logic [csp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do
            @(posedge clk);
        while (!cfg.ready);
        cfg.valid <= 1'b0;
        if (idx == csp_pkg::REG_RADIUS)
            radius_val = longint'(value[30:0]);
        else if (idx < csp_pkg::REG_TOP_X)
            bottom_pt[idx] = longint'($signed(value));
        else
            top_pt[idx - csp_pkg::REG_TOP_X] = longint'($signed(value));
        @(posedge clk);
    endtask

    task automatic drain();
        query.valid <= 1'b0;
        wait (points_due.size() == 0);
        repeat (90) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return $urandom_range(1, 0) ? 32'h7fffffff : 32'h80000000;
            1, 2: return 32'($signed($urandom_range(2000000)) - 1000000);
            3: return 32'($signed($urandom_range(200)) - 100);
            default: return $urandom;
        endcase
    endfunction

    task automatic load_cylinder(logic [31:0] bx, logic [31:0] by, logic [31:0] bz,
                                 logic [31:0] tx, logic [31:0] ty, logic [31:0] tz,
                                 logic [31:0] rad);
        write_reg(csp_pkg::REG_BOTTOM_X, bx);
        write_reg(csp_pkg::REG_BOTTOM_Y, by);
        write_reg(csp_pkg::REG_BOTTOM_Z, bz);
        write_reg(csp_pkg::REG_TOP_X, tx);
        write_reg(csp_pkg::REG_TOP_Y, ty);
        write_reg(csp_pkg::REG_TOP_Z, tz);
        write_reg(csp_pkg::REG_RADIUS, rad);
    endtask

    query_row_t directed[] = '{
        '{csp_pkg::MODE_AUTO,   32'h00010000, 32'h0, 32'h0, 1'b1,
          '{32'h00010000, 32'h0, 32'h0, 1'b0}},
        '{csp_pkg::MODE_TOP,    32'h00010000, 32'h0, 32'h0, 1'b1,
          '{32'h00010000, 32'h00010000, 32'h0, 1'b1}},
        '{csp_pkg::MODE_AUTO,   32'h0, 32'h0, 32'h0, 1'b1,
          '{32'h0, 32'h0, 32'h0, 1'b0}},
        '{csp_pkg::MODE_AUTO,   32'h0, 32'h5, 32'h0, 1'b1,
          '{32'h0, 32'h00010000, 32'h0, 1'b1}},
        '{csp_pkg::MODE_BOTTOM, 32'h0, 32'h0, 32'hffff0000, 1'b1,
          '{32'h0, 32'h0, 32'hffff0000, 1'b0}},
        '{csp_pkg::MODE_BOTTOM, 32'h0, 32'h7fffffff, 32'h0, 1'b1,
          '{32'h0, 32'h0, 32'h0, 1'b0}},
        '{2'd3,        32'h12345678, 32'h9abcdef0, 32'h0fedcba9, 1'b0, '{0, 0, 0, 0}},
        '{csp_pkg::MODE_AUTO,   32'h80000000, 32'h80000000, 32'h80000000, 1'b0,
          '{0, 0, 0, 0}},
        '{csp_pkg::MODE_AUTO,   32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0,
          '{0, 0, 0, 0}},
        '{csp_pkg::MODE_TOP,    32'h80000000, 32'h7fffffff, 32'h00000001, 1'b0,
          '{0, 0, 0, 0}},
        '{csp_pkg::MODE_AUTO,   32'h00000041, 32'hffffffbf, 32'h00000010, 1'b0,
          '{0, 0, 0, 0}},
        '{csp_pkg::MODE_AUTO,   32'h00000042, 32'h0, 32'h0, 1'b0, '{0, 0, 0, 0}},
        '{csp_pkg::MODE_BOTTOM, 32'hffffffff, 32'h00000001, 32'hffffffff, 1'b0,
          '{0, 0, 0, 0}},
        '{csp_pkg::MODE_TOP,    32'h55555555, 32'haaaaaaaa, 32'hffffffff, 1'b0,
          '{0, 0, 0, 0}}
    };

    initial
    begin
        logic [csp_pkg::MODE_W-1:0] m;
        support_t none;
        none = '{0, 0, 0, 0};
        query.valid = 1'b0;
        query.mode  = '0;
        query.dir_x = '0;
        query.dir_y = '0;
        query.dir_z = '0;
        cfg.valid   = 1'b0;
        cfg.index   = '0;
        cfg.data    = '0;
        for (int i = 0; i < 3; i++)
        begin
            bottom_pt[i] = 0;
            top_pt[i] = 0;
        end
        top_pt[1] = 65536;
        radius_val = 65536;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
            send_query(directed[i].mode, directed[i].dx, directed[i].dy,
                       directed[i].dz, directed[i].typed, directed[i].want);
        drain();

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                1: load_cylinder(32'h80000000, 32'h80000000, 32'h80000000,
                                 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
                2: load_cylinder(32'h00030000, 32'hfffd0000, 32'h0, 32'h00030000,
                                 32'hfffd0000, 32'h0, 32'h00008000);
                3: load_cylinder(32'h0, 32'h0, 32'h0, 32'h00000001, 32'h0, 32'h0,
                                 32'h0);
                4: load_cylinder(32'h7fff0000, 32'h0, 32'h0, 32'h7fff0000,
                                 32'h00100000, 32'h0, 32'h7fffffff);
                default:
                    if (ph != 0)
                        load_cylinder(rand_coord(), rand_coord(), rand_coord(),
                                      rand_coord(), rand_coord(), rand_coord(),
                                      $urandom_range(1, 0) ? $urandom
                                                           : $urandom_range(400000));
            endcase
            idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 28 : 81) : 0;
            stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 28 : 81) : 0;
            if (ph == 4)
            begin
                idle_pct = 0;
                stall_pct = 0;
                hold_len = 400;
            end
            for (int n = 0; n < 110; n++)
            begin
                m = $urandom_range(3);
                if ($urandom_range(9) < 7)
                    m = $urandom_range(2);
                send_query(m, rand_coord(), rand_coord(), rand_coord(), 1'b0, none);
            end
            drain();
        end

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
